[design/psp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

   // Fixed point one in Q16.16.
   localparam int Q_ONE = 65536;

   // Datapath widths.
   localparam int DVS_W   = 64;   // squared direction length
   localparam int REM_D_W = 128;  // distance dividend after the range check
   localparam int REM_T_W = 96;   // line parameter dividend after the range check
   localparam int Q_D_W   = 64;   // distance quotient bits
   localparam int Q_T_W   = 32;   // line parameter quotient bits
   localparam int ROOT_W  = 64;   // square root operand

   // Pipeline depths.
   localparam int FRONT_STAGES = 8;
   localparam int DIV_D_STEPS  = Q_D_W;
   localparam int DIV_T_STEPS  = Q_T_W;
   localparam int ROOT_STEPS   = ROOT_W / 2;
   localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_D_STEPS + ROOT_STEPS;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_START_X   = 3'd0,
      CSR_START_Y   = 3'd1,
      CSR_START_Z   = 3'd2,
      CSR_DIR_X     = 3'd3,
      CSR_DIR_Y     = 3'd4,
      CSR_DIR_Z     = 3'd5,
      CSR_TOLERANCE = 3'd6,
      CSR_THREE_D   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] line_param;
      logic [31:0]        distance;
      logic               in_box;
      logic               within_segment;
      logic               degenerate;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic [15:0]        tolerance;
      logic               three_d;
   } cfg_type;

   // Status of one item leaving the front end.
   typedef struct packed {
      logic neg;
      logic degen;
      logic box;
      logic big_t;
      logic big_d;
   } flags_type;

   // Side data riding along the line parameter divider.
   typedef struct packed {
      logic neg;
      logic big_t;
      logic degen;
      logic box;
   } ttag_type;

   // Side data riding along the distance divider and the root.
   typedef struct packed {
      logic signed [31:0] line_param;
      logic               in_range;
      logic               box;
      logic               degen;
      logic               big_d;
   } dtag_type;

endpackage

`default_nettype wire

[design/point_segment_projection.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake            Payload
// req_       in         req_valid/req_stall  req_data (point_x, point_y, point_z)
// rsp_       out        rsp_valid/rsp_stall  rsp_data (line_param, distance, flags)
// csr_       in         csr_valid/csr_ready  csr_index, csr_data
//
// One point is taken every cycle unless req_stall is high; rsp_valid rises when its result reaches the result register.
// The depth is set by the distance divider (64 steps), the root (32 steps) and the
// eight front stages for the products; the line parameter divider runs alongside.
// A stalled result freezes the whole pipeline, so req_stall is high while rsp_valid and rsp_stall are both high.
// Reset clears all valid bits and loads the register defaults; csr_ready is tied high.
module point_segment_projection
   import psp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   // Configuration registers.
   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_x   <= 32'sd0;
         cfg_ff.start_y   <= 32'sd0;
         cfg_ff.start_z   <= 32'sd0;
         cfg_ff.dir_x     <= 32'(Q_ONE);
         cfg_ff.dir_y     <= 32'sd0;
         cfg_ff.dir_z     <= 32'sd0;
         cfg_ff.tolerance <= 16'd1;
         cfg_ff.three_d   <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_START_X:   cfg_ff.start_x   <= csr_data;
            CSR_START_Y:   cfg_ff.start_y   <= csr_data;
            CSR_START_Z:   cfg_ff.start_z   <= csr_data;
            CSR_DIR_X:     cfg_ff.dir_x     <= csr_data;
            CSR_DIR_Y:     cfg_ff.dir_y     <= csr_data;
            CSR_DIR_Z:     cfg_ff.dir_z     <= csr_data;
            CSR_TOLERANCE: cfg_ff.tolerance <= csr_data[15:0];
            CSR_THREE_D:   cfg_ff.three_d   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline advance: everything moves unless a finished result is held.
   logic                  advance;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   // Front end.
   logic [REM_D_W-1:0] f_num;
   logic [REM_T_W-1:0] f_tn;
   logic [DVS_W-1:0]   f_dvs;
   flags_type          f_flags;

   psp_front u_front (
      .clock   (clock),
      .en      (advance),
      .req_in  (req_data),
      .cfg     (cfg_ff),
      .num_rem (f_num),
      .tn_rem  (f_tn),
      .dvs     (f_dvs),
      .flags   (f_flags)
   );

   // Line parameter divider.
   logic [REM_T_W-1:0] trem [DIV_T_STEPS+1];
   logic [DVS_W-1:0]   tdvs [DIV_T_STEPS+1];
   logic [Q_T_W-1:0]   tq   [DIV_T_STEPS+1];
   ttag_type           ttag [DIV_T_STEPS+1];

   assign trem[0]       = f_tn;
   assign tdvs[0]       = f_dvs;
   assign tq[0]         = '0;
   assign ttag[0].neg   = f_flags.neg;
   assign ttag[0].big_t = f_flags.big_t;
   assign ttag[0].degen = f_flags.degen;
   assign ttag[0].box   = f_flags.box;

   for (genvar k = 0; k < DIV_T_STEPS; k++) begin : g_tdiv
      psp_div_cell #(
         .REM_W (REM_T_W),
         .DVS_W (DVS_W),
         .Q_W   (Q_T_W),
         .SHIFT (DIV_T_STEPS - 1 - k),
         .TAG_W ($bits(ttag_type))
      ) u_cell (
         .clock   (clock),
         .en      (advance),
         .rem_in  (trem[k]),
         .dvs_in  (tdvs[k]),
         .q_in    (tq[k]),
         .tag_in  (ttag[k]),
         .rem_out (trem[k+1]),
         .dvs_out (tdvs[k+1]),
         .q_out   (tq[k+1]),
         .tag_out (ttag[k+1])
      );
   end

   // Saturate the quotient and check the parameter range.
   ttag_type           tt;
   logic [Q_T_W-1:0]   tqv;
   logic [Q_T_W-1:0]   tq_neg;
   logic signed [31:0] lp;
   logic signed [33:0] lp34;
   logic signed [33:0] lo34;
   logic signed [33:0] hi34;
   dtag_type           merged;

   always_comb begin
      tt     = ttag[DIV_T_STEPS];
      tqv    = tq[DIV_T_STEPS];
      tq_neg = -tqv;
      if (tt.degen) begin
         lp = 32'sd0;
      end else if (tt.neg) begin
         if (tt.big_t || (tqv[31] && (|tqv[30:0]))) begin
            lp = 32'sh8000_0000;
         end else begin
            lp = tq_neg;
         end
      end else begin
         if (tt.big_t || tqv[31]) begin
            lp = 32'sh7FFF_FFFF;
         end else begin
            lp = tqv;
         end
      end
      lp34 = {{2{lp[31]}}, lp};
      lo34 = -$signed({18'b0, cfg_ff.tolerance});
      hi34 = 34'(Q_ONE) + $signed({18'b0, cfg_ff.tolerance});
      merged.line_param = lp;
      merged.in_range   = (lp34 >= lo34) && (lp34 <= hi34);
      merged.box        = tt.box;
      merged.degen      = tt.degen;
      merged.big_d      = 1'b0;
   end

   // Distance divider; the line parameter joins its side data halfway.
   logic [REM_D_W-1:0] drem [DIV_D_STEPS+1];
   logic [DVS_W-1:0]   ddvs [DIV_D_STEPS+1];
   logic [Q_D_W-1:0]   dq   [DIV_D_STEPS+1];
   dtag_type           dtag [DIV_D_STEPS+1];

   assign drem[0]            = f_num;
   assign ddvs[0]            = f_dvs;
   assign dq[0]              = '0;
   assign dtag[0].line_param = 32'sd0;
   assign dtag[0].in_range   = 1'b0;
   assign dtag[0].box        = 1'b0;
   assign dtag[0].degen      = 1'b0;
   assign dtag[0].big_d      = f_flags.big_d;

   for (genvar k = 0; k < DIV_D_STEPS; k++) begin : g_ddiv
      dtag_type tag_k;
      if (k == DIV_T_STEPS) begin : g_join
         always_comb begin
            tag_k       = merged;
            tag_k.big_d = dtag[k].big_d;
         end
      end else begin : g_pass
         assign tag_k = dtag[k];
      end

      psp_div_cell #(
         .REM_W (REM_D_W),
         .DVS_W (DVS_W),
         .Q_W   (Q_D_W),
         .SHIFT (DIV_D_STEPS - 1 - k),
         .TAG_W ($bits(dtag_type))
      ) u_cell (
         .clock   (clock),
         .en      (advance),
         .rem_in  (drem[k]),
         .dvs_in  (ddvs[k]),
         .q_in    (dq[k]),
         .tag_in  (tag_k),
         .rem_out (drem[k+1]),
         .dvs_out (ddvs[k+1]),
         .q_out   (dq[k+1]),
         .tag_out (dtag[k+1])
      );
   end

   // Square root of the squared distance.
   logic [ROOT_W-1:0] sx   [ROOT_STEPS+1];
   logic [ROOT_W-1:0] sres [ROOT_STEPS+1];
   dtag_type          stag [ROOT_STEPS+1];

   assign sx[0]   = dtag[DIV_D_STEPS].big_d ? '0 : dq[DIV_D_STEPS];
   assign sres[0] = '0;
   assign stag[0] = dtag[DIV_D_STEPS];

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      psp_sqrt_cell #(
         .ONE_POS (ROOT_W - 2 - 2 * k),
         .TAG_W   ($bits(dtag_type))
      ) u_cell (
         .clock   (clock),
         .en      (advance),
         .x_in    (sx[k]),
         .res_in  (sres[k]),
         .tag_in  (stag[k]),
         .x_out   (sx[k+1]),
         .res_out (sres[k+1]),
         .tag_out (stag[k+1])
      );
   end

   // Result register.
   rsp_type  rsp_in;
   dtag_type fin;

   always_comb begin
      fin                   = stag[ROOT_STEPS];
      rsp_in.line_param     = fin.line_param;
      rsp_in.distance       = fin.big_d ? 32'hFFFF_FFFF : sres[ROOT_STEPS][31:0];
      rsp_in.in_box         = fin.box;
      rsp_in.within_segment = fin.in_range;
      rsp_in.degenerate     = fin.degen;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[design/psp_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One restoring division step: subtract the divisor at a fixed weight.
module psp_div_cell #(
   parameter int REM_W = 128,
   parameter int DVS_W = 64,
   parameter int Q_W   = 64,
   parameter int SHIFT = 0,
   parameter int TAG_W = 1
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [REM_W-1:0] rem_in,
   input  wire logic [DVS_W-1:0] dvs_in,
   input  wire logic [Q_W-1:0]   q_in,
   input  wire logic [TAG_W-1:0] tag_in,
   output logic      [REM_W-1:0] rem_out,
   output logic      [DVS_W-1:0] dvs_out,
   output logic      [Q_W-1:0]   q_out,
   output logic      [TAG_W-1:0] tag_out
);

   logic [REM_W:0]   weight;
   logic [REM_W:0]   trial;
   logic             take;
   logic [REM_W-1:0] rem_in_next;
   logic [Q_W-1:0]   q_in_next;

   logic [REM_W-1:0] rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [Q_W-1:0]   q_ff;
   logic [TAG_W-1:0] tag_ff;

   // Trial subtraction of the shifted divisor.
   always_comb begin
      weight      = {{(REM_W + 1 - DVS_W){1'b0}}, dvs_in} << SHIFT;
      trial       = {1'b0, rem_in} - weight;
      take        = !trial[REM_W];
      rem_in_next = take ? trial[REM_W-1:0] : rem_in;
      q_in_next   = {q_in[Q_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in_next;
         dvs_ff <= dvs_in;
         q_ff   <= q_in_next;
         tag_ff <= tag_in;
      end
   end

   assign rem_out = rem_ff;
   assign dvs_out = dvs_ff;
   assign q_out   = q_ff;
   assign tag_out = tag_ff;

endmodule

`default_nettype wire

[design/psp_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One step of the digit by digit integer square root.
module psp_sqrt_cell
   import psp_pkg::*;
#(
   parameter int ONE_POS = 62,
   parameter int TAG_W   = 1
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [ROOT_W-1:0] x_in,
   input  wire logic [ROOT_W-1:0] res_in,
   input  wire logic [TAG_W-1:0]  tag_in,
   output logic      [ROOT_W-1:0] x_out,
   output logic      [ROOT_W-1:0] res_out,
   output logic      [TAG_W-1:0]  tag_out
);

   localparam logic [ROOT_W-1:0] ONE = {{(ROOT_W - 1){1'b0}}, 1'b1} << ONE_POS;

   logic [ROOT_W:0]   trial;
   logic              take;
   logic [ROOT_W-1:0] x_in_next;
   logic [ROOT_W-1:0] res_in_next;

   logic [ROOT_W-1:0] x_ff;
   logic [ROOT_W-1:0] res_ff;
   logic [TAG_W-1:0]  tag_ff;

   // Take the digit when the remainder covers the trial value.
   always_comb begin
      trial       = {1'b0, x_in} - {1'b0, res_in + ONE};
      take        = !trial[ROOT_W];
      x_in_next   = take ? trial[ROOT_W-1:0] : x_in;
      res_in_next = take ? ((res_in >> 1) + ONE) : (res_in >> 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x_in_next;
         res_ff <= res_in_next;
         tag_ff <= tag_in;
      end
   end

   assign x_out   = x_ff;
   assign res_out = res_ff;
   assign tag_out = tag_ff;

endmodule

`default_nettype wire

[design/psp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

// Products, cross product, squares and range checks ahead of the dividers.
module psp_front
   import psp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                en,
   input  wire req_type             req_in,
   input  wire cfg_type             cfg,
   output logic      [REM_D_W-1:0]  num_rem,
   output logic      [REM_T_W-1:0]  tn_rem,
   output logic      [DVS_W-1:0]    dvs,
   output flags_type                flags
);

   // Configuration with the z axis masked in two-dimensional mode.
   logic signed [31:0] sm [3];
   logic signed [31:0] dm [3];
   logic signed [31:0] pm [3];

   always_comb begin
      sm[0] = cfg.start_x;
      sm[1] = cfg.start_y;
      sm[2] = cfg.three_d ? cfg.start_z : 32'sd0;
      dm[0] = cfg.dir_x;
      dm[1] = cfg.dir_y;
      dm[2] = cfg.three_d ? cfg.dir_z : 32'sd0;
      pm[0] = req_in.point_x;
      pm[1] = req_in.point_y;
      pm[2] = cfg.three_d ? req_in.point_z : 32'sd0;
   end

   // Stage 1: offset from the start and tolerance-shifted point.
   logic signed [32:0] e1_in  [3];
   logic signed [33:0] pt1_in [3];
   logic signed [33:0] pn1_in [3];
   logic signed [32:0] e1_ff  [3];
   logic signed [33:0] pt1_ff [3];
   logic signed [33:0] pn1_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i]  = $signed({pm[i][31], pm[i]}) - $signed({sm[i][31], sm[i]});
         pt1_in[i] = $signed({{2{pm[i][31]}}, pm[i]}) + $signed({18'b0, cfg.tolerance});
         pn1_in[i] = $signed({{2{pm[i][31]}}, pm[i]}) - $signed({18'b0, cfg.tolerance});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff  <= e1_in;
         pt1_ff <= pt1_in;
         pn1_ff <= pn1_in;
      end
   end

   // Stage 2: all offset by direction products, direction squares, box test.
   logic signed [64:0] prod2_in [3][3];
   logic signed [63:0] dsq2_in  [3];
   logic signed [33:0] s34      [3];
   logic signed [33:0] b34      [3];
   logic [2:0]         axis_ok;
   logic signed [64:0] prod2_ff [3][3];
   logic signed [63:0] dsq2_ff  [3];
   logic signed [32:0] e2_ff    [3];
   logic               box2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod2_in[i][j] = e1_ff[i] * dm[j];
         end
         dsq2_in[i] = dm[i] * dm[i];
         s34[i]     = $signed({{2{sm[i][31]}}, sm[i]});
         b34[i]     = s34[i] + $signed({{2{dm[i][31]}}, dm[i]});
         axis_ok[i] = ((pt1_ff[i] >= s34[i]) || (pt1_ff[i] >= b34[i]))
                   && ((pn1_ff[i] <= s34[i]) || (pn1_ff[i] <= b34[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod2_ff <= prod2_in;
         dsq2_ff  <= dsq2_in;
         e2_ff    <= e1_ff;
         box2_ff  <= &axis_ok;
      end
   end

   // Stage 3: dot product, squared length, cross product.
   logic signed [66:0] dot3_in;
   logic [63:0]        dd3_in;
   logic signed [65:0] c3_in [3];
   logic signed [66:0] dot3_ff;
   logic [63:0]        dd3_ff;
   logic signed [65:0] c3_ff [3];
   logic signed [32:0] e3_ff [3];
   logic               box3_ff;

   always_comb begin
      dot3_in  = prod2_ff[0][0] + prod2_ff[1][1] + prod2_ff[2][2];
      dd3_in   = dsq2_ff[0] + dsq2_ff[1] + dsq2_ff[2];
      c3_in[0] = prod2_ff[1][2] - prod2_ff[2][1];
      c3_in[1] = prod2_ff[2][0] - prod2_ff[0][2];
      c3_in[2] = prod2_ff[0][1] - prod2_ff[1][0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dot3_ff <= dot3_in;
         dd3_ff  <= dd3_in;
         c3_ff   <= c3_in;
         e3_ff   <= e2_ff;
         box3_ff <= box2_ff;
      end
   end

   // Stage 4: magnitudes; a zero direction squares the offset over a divisor of one.
   logic               degen4_in;
   logic signed [66:0] dot_neg;
   logic [65:0]        mag4_in;
   logic signed [65:0] c_neg [3];
   logic signed [32:0] e_neg [3];
   logic [63:0]        a4_in [3];
   logic [63:0]        a4_ff [3];
   logic [65:0]        mag4_ff;
   logic [DVS_W-1:0]   dvs4_ff;
   logic               neg4_ff;
   logic               degen4_ff;
   logic               box4_ff;

   always_comb begin
      degen4_in = (dd3_ff == 64'd0);
      dot_neg   = -dot3_ff;
      mag4_in   = dot3_ff[66] ? dot_neg[65:0] : dot3_ff[65:0];
      for (int k = 0; k < 3; k++) begin
         c_neg[k] = -c3_ff[k];
         e_neg[k] = -e3_ff[k];
         if (degen4_in) begin
            a4_in[k] = {32'b0, (e3_ff[k][32] ? e_neg[k][31:0] : e3_ff[k][31:0])};
         end else begin
            a4_in[k] = c3_ff[k][65] ? c_neg[k][63:0] : c3_ff[k][63:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a4_ff     <= a4_in;
         mag4_ff   <= mag4_in;
         dvs4_ff   <= degen4_in ? {{(DVS_W - 1){1'b0}}, 1'b1} : dd3_ff;
         neg4_ff   <= dot3_ff[66];
         degen4_ff <= degen4_in;
         box4_ff   <= box3_ff;
      end
   end

   // Stage 5: 32 by 32 partial products of each square.
   logic [63:0]      ll5_ff [3];
   logic [63:0]      lh5_ff [3];
   logic [63:0]      hh5_ff [3];
   logic [65:0]      mag5_ff;
   logic [DVS_W-1:0] dvs5_ff;
   logic             neg5_ff;
   logic             degen5_ff;
   logic             box5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            ll5_ff[k] <= a4_ff[k][31:0] * a4_ff[k][31:0];
            lh5_ff[k] <= a4_ff[k][31:0] * a4_ff[k][63:32];
            hh5_ff[k] <= a4_ff[k][63:32] * a4_ff[k][63:32];
         end
         mag5_ff   <= mag4_ff;
         dvs5_ff   <= dvs4_ff;
         neg5_ff   <= neg4_ff;
         degen5_ff <= degen4_ff;
         box5_ff   <= box4_ff;
      end
   end

   // Stage 6: assemble each square.
   logic [127:0]     sq6_ff [3];
   logic [65:0]      mag6_ff;
   logic [DVS_W-1:0] dvs6_ff;
   logic             neg6_ff;
   logic             degen6_ff;
   logic             box6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            sq6_ff[k] <= {hh5_ff[k], 64'b0} + {31'b0, lh5_ff[k], 33'b0}
                       + {64'b0, ll5_ff[k]};
         end
         mag6_ff   <= mag5_ff;
         dvs6_ff   <= dvs5_ff;
         neg6_ff   <= neg5_ff;
         degen6_ff <= degen5_ff;
         box6_ff   <= box5_ff;
      end
   end

   // Stage 7: sum of squares and scaled dot product.
   logic [129:0]     num7_ff;
   logic [81:0]      tn7_ff;
   logic [DVS_W-1:0] dvs7_ff;
   logic             neg7_ff;
   logic             degen7_ff;
   logic             box7_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         num7_ff   <= {2'b0, sq6_ff[0]} + {2'b0, sq6_ff[1]} + {2'b0, sq6_ff[2]};
         tn7_ff    <= {mag6_ff, 16'b0};
         dvs7_ff   <= dvs6_ff;
         neg7_ff   <= neg6_ff;
         degen7_ff <= degen6_ff;
         box7_ff   <= box6_ff;
      end
   end

   // Stage 8: quotient range checks ahead of the dividers.
   logic [REM_D_W-1:0] num8_ff;
   logic [REM_T_W-1:0] tn8_ff;
   logic [DVS_W-1:0]   dvs8_ff;
   flags_type          flags8_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         num8_ff         <= num7_ff[REM_D_W-1:0];
         tn8_ff          <= {14'b0, tn7_ff};
         dvs8_ff         <= dvs7_ff;
         flags8_ff.big_d <= (num7_ff >= {2'b0, dvs7_ff, 64'b0});
         flags8_ff.big_t <= ({14'b0, tn7_ff} >= {dvs7_ff, 32'b0});
         flags8_ff.neg   <= neg7_ff;
         flags8_ff.degen <= degen7_ff;
         flags8_ff.box   <= box7_ff;
      end
   end

   assign num_rem = num8_ff;
   assign tn_rem  = tn8_ff;
   assign dvs     = dvs8_ff;
   assign flags   = flags8_ff;

endmodule

`default_nettype wire
